// ----- hdl/cube_cross_ray_direction_defines.svh -----
// Assertion macros shared by the checker of the cube cross ray direction block.
// Depends on nothing; included by the checker file.
`ifndef CUBE_CROSS_RAY_DIRECTION_DEFINES_SVH
`define CUBE_CROSS_RAY_DIRECTION_DEFINES_SVH

// Implication checked on every edge outside reset.
`define CCRD_ASSERT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ccrd check failed");

// Next-cycle implication that is also checked while reset is high.
`define CCRD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("ccrd check failed");

`endif

// ----- hdl/ccrd_pkg.sv -----
// Package of the cube cross ray direction block: widths, codes and types.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package ccrd_pkg;

  localparam int REG_W       = 13;
  localparam int POS_W       = 16;
  localparam int DIR_W       = 16;
  localparam int FACE_W      = 3;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 56;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam int COORD_FRAC_BITS_DEF = 4;
  localparam int DIR_FRAC_BITS_DEF   = 14;

  localparam logic [REG_W-1:0] WIDTH_RESET  = 13'd1024;
  localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd768;

  localparam logic REG_SEL_WIDTH  = 1'b0;
  localparam logic REG_SEL_HEIGHT = 1'b1;

  localparam logic [31:0] DIV3_MUL   = 32'd43691;
  localparam int          DIV3_SHIFT = 17;

  typedef enum logic [FACE_W-1:0] {
    FACE_UP    = 3'd0,
    FACE_FRONT = 3'd1,
    FACE_DOWN  = 3'd2,
    FACE_LEFT  = 3'd3,
    FACE_RIGHT = 3'd4,
    FACE_BACK  = 3'd5,
    FACE_NONE  = 3'd6
  } face_t;

  typedef struct packed {
    face_t face;
    logic  row_neg;
    logic  row_sat;
    logic  row_zero;
    logic  col_neg;
    logic  col_sat;
    logic  col_zero;
  } ccrd_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/ccrd_classify.sv -----
// Input register and face classification; prepares the two division lanes.
// Depends on ccrd_pkg.
`default_nettype none

module ccrd_classify
  import ccrd_pkg::*;
#(
  parameter int CFB = COORD_FRAC_BITS_DEF,
  parameter int DFB = DIR_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [POS_W-1:0]      col_pos,
  input  logic [POS_W-1:0]      row_pos,
  input  logic [REG_W-1:0]      image_width,
  input  logic [REG_W-1:0]      image_height,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ccrd_ctl_t             ctl,
  output logic [REG_W+CFB-1:0]  row_rem,
  output logic [DFB:0]          row_low,
  output logic [REG_W+CFB-1:0]  col_rem,
  output logic [DFB:0]          col_low
);

  localparam int DW   = REG_W + CFB;
  localparam int CMPW = ((DW > POS_W) ? DW : POS_W) + 3;
  localparam int NW   = CMPW + 1;
  localparam int NNW  = DW + DFB + 1;

  logic             v1;
  logic [POS_W-1:0] c1;
  logic [POS_W-1:0] r1;
  logic             ready1;
  logic             ready2;

  logic [DW-1:0]   q1b;
  logic [DW-1:0]   halfb;
  logic [DW-1:0]   t1b;
  logic [DW-1:0]   t2b;
  logic [CMPW-1:0] w3x;
  logic [CMPW-1:0] h2x;
  logic [DW-1:0]   den_w;
  logic [DW-1:0]   den_h;
  logic [31:0]     t1_prod;
  logic [31:0]     t2_prod;

  logic          mid_col;
  logic          mid_row;
  logic [CMPW-1:0] c4;
  logic [CMPW-1:0] r3;
  face_t         face;
  logic [2:0]    row_k;
  logic [2:0]    col_k;
  logic          row_flip;
  logic          col_flip;
  logic signed [NW-1:0] rnum;
  logic signed [NW-1:0] cnum;
  logic signed [NW-1:0] rnum_s;
  logic signed [NW-1:0] cnum_s;
  logic [NW-1:0]  rmag;
  logic [NW-1:0]  cmag;
  logic [NNW-1:0] rn;
  logic [NNW-1:0] cn;

  assign ready2   = !out_valid || out_ready;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  assign t1_prod = 32'(image_height) * DIV3_MUL;
  assign t2_prod = 32'({image_height, 1'b0}) * DIV3_MUL;

  always_ff @(posedge clk) begin
    q1b   <= DW'(image_width >> 2) << CFB;
    halfb <= DW'(image_width >> 1) << CFB;
    t1b   <= DW'(t1_prod >> DIV3_SHIFT) << CFB;
    t2b   <= DW'(t2_prod >> DIV3_SHIFT) << CFB;
    w3x   <= (CMPW'(image_width) * CMPW'(3)) << CFB;
    h2x   <= (CMPW'(image_height) * CMPW'(2)) << CFB;
    den_w <= DW'(image_width) << CFB;
    den_h <= DW'(image_height) << CFB;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      c1 <= col_pos;
      r1 <= row_pos;
    end
  end

  always_comb begin
    c4      = CMPW'(c1) << 2;
    r3      = CMPW'(r1) * CMPW'(3);
    mid_col = (CMPW'(c1) >= CMPW'(q1b)) && (CMPW'(c1) < CMPW'(halfb));
    mid_row = (CMPW'(r1) > CMPW'(t1b)) && (CMPW'(r1) < CMPW'(t2b));
    face     = FACE_NONE;
    row_k    = 3'd3;
    row_flip = 1'b1;
    col_k    = 3'd3;
    col_flip = 1'b0;
    if (mid_col && (CMPW'(r1) < CMPW'(t1b))) begin
      face     = FACE_UP;
      row_k    = 3'd1;
      row_flip = 1'b0;
    end else if (mid_col && mid_row) begin
      face = FACE_FRONT;
    end else if (mid_col && (r3 > h2x)) begin
      face  = FACE_DOWN;
      row_k = 3'd5;
    end else if ((CMPW'(c1) < CMPW'(q1b)) && mid_row) begin
      face  = FACE_LEFT;
      col_k = 3'd1;
    end else if ((CMPW'(c1) > CMPW'(halfb)) && (c4 < w3x) && mid_row) begin
      face     = FACE_RIGHT;
      col_k    = 3'd5;
      col_flip = 1'b1;
    end else if ((c4 > w3x) && mid_row) begin
      face     = FACE_BACK;
      col_k    = 3'd7;
      col_flip = 1'b1;
    end

    rnum   = $signed(NW'(r1) * NW'(6)) - $signed(NW'(den_h) * NW'(row_k));
    cnum   = $signed(NW'(c1) * NW'(8)) - $signed(NW'(den_w) * NW'(col_k));
    rnum_s = row_flip ? -rnum : rnum;
    cnum_s = col_flip ? -cnum : cnum;
    rmag   = rnum_s[NW-1] ? NW'(-rnum_s) : NW'(rnum_s);
    cmag   = cnum_s[NW-1] ? NW'(-cnum_s) : NW'(cnum_s);
    rn     = (NNW'(rmag[DW-1:0]) << DFB) + NNW'(den_h >> 1);
    cn     = (NNW'(cmag[DW-1:0]) << DFB) + NNW'(den_w >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      ctl.face     <= face;
      ctl.row_neg  <= rnum_s[NW-1];
      ctl.row_sat  <= rmag >= NW'(den_h);
      ctl.row_zero <= rmag == '0;
      ctl.col_neg  <= cnum_s[NW-1];
      ctl.col_sat  <= cmag >= NW'(den_w);
      ctl.col_zero <= cmag == '0;
      row_rem      <= rn[NNW-1 -: DW];
      row_low      <= rn[DFB:0];
      col_rem      <= cn[NNW-1 -: DW];
      col_low      <= cn[DFB:0];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ccrd_div_cell.sv -----
// One cell of the division chain: one quotient bit for each of the two lanes.
// Depends on ccrd_pkg.
`default_nettype none

module ccrd_div_cell
  import ccrd_pkg::*;
#(
  parameter int CFB = COORD_FRAC_BITS_DEF,
  parameter int DFB = DIR_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  logic [REG_W+CFB-1:0]  den_row,
  input  logic [REG_W+CFB-1:0]  den_col,
  input  ccrd_ctl_t             ctl_in,
  input  logic [REG_W+CFB-1:0]  row_rem_in,
  input  logic [DFB:0]          row_low_in,
  input  logic [DFB:0]          row_q_in,
  input  logic [REG_W+CFB-1:0]  col_rem_in,
  input  logic [DFB:0]          col_low_in,
  input  logic [DFB:0]          col_q_in,
  output ccrd_ctl_t             ctl_out,
  output logic [REG_W+CFB-1:0]  row_rem_out,
  output logic [DFB:0]          row_low_out,
  output logic [DFB:0]          row_q_out,
  output logic [REG_W+CFB-1:0]  col_rem_out,
  output logic [DFB:0]          col_low_out,
  output logic [DFB:0]          col_q_out
);

  localparam int DW = REG_W + CFB;

  logic          ready;
  logic [DW:0]   row_t;
  logic [DW:0]   row_d;
  logic          row_ge;
  logic [DW:0]   col_t;
  logic [DW:0]   col_d;
  logic          col_ge;

  assign ready    = !out_valid || out_ready;
  assign in_ready = ready;

  always_comb begin
    row_t  = {row_rem_in, row_low_in[DFB]};
    row_d  = row_t - {1'b0, den_row};
    row_ge = row_t >= {1'b0, den_row};
    col_t  = {col_rem_in, col_low_in[DFB]};
    col_d  = col_t - {1'b0, den_col};
    col_ge = col_t >= {1'b0, den_col};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      ctl_out     <= ctl_in;
      row_rem_out <= row_ge ? row_d[DW-1:0] : row_t[DW-1:0];
      row_low_out <= row_low_in << 1;
      row_q_out   <= {row_q_in[DFB-1:0], row_ge};
      col_rem_out <= col_ge ? col_d[DW-1:0] : col_t[DW-1:0];
      col_low_out <= col_low_in << 1;
      col_q_out   <= {col_q_in[DFB-1:0], col_ge};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ccrd_pack.sv -----
// Output register: applies saturation and sign, places the offsets by face.
// Depends on ccrd_pkg.
`default_nettype none

module ccrd_pack
  import ccrd_pkg::*;
#(
  parameter int DFB = DIR_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ccrd_ctl_t             ctl,
  input  logic [DFB:0]          row_q,
  input  logic [DFB:0]          col_q,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam logic [DFB:0] ONE_Q = (DFB+1)'(1) << DFB;

  logic                 ready;
  logic [DFB:0]         row_mag;
  logic [DFB:0]         col_mag;
  logic signed [31:0]   row_v;
  logic signed [31:0]   col_v;
  logic signed [31:0]   one_v;
  logic signed [31:0]   x;
  logic signed [31:0]   y;
  logic signed [31:0]   z;

  assign ready    = !out_valid || out_ready;
  assign in_ready = ready;

  always_comb begin
    row_mag = ctl.row_zero ? '0 : (ctl.row_sat ? ONE_Q : row_q);
    col_mag = ctl.col_zero ? '0 : (ctl.col_sat ? ONE_Q : col_q);
    row_v   = ctl.row_neg ? -$signed(32'(row_mag)) : $signed(32'(row_mag));
    col_v   = ctl.col_neg ? -$signed(32'(col_mag)) : $signed(32'(col_mag));
    one_v   = $signed(32'(ONE_Q));
    x = '0;
    y = '0;
    z = '0;
    unique case (ctl.face)
      FACE_UP: begin
        x = row_v; y = one_v; z = col_v;
      end
      FACE_FRONT: begin
        x = one_v; y = row_v; z = col_v;
      end
      FACE_DOWN: begin
        x = row_v; y = -one_v; z = col_v;
      end
      FACE_LEFT: begin
        x = col_v; y = row_v; z = -one_v;
      end
      FACE_RIGHT: begin
        x = col_v; y = row_v; z = one_v;
      end
      FACE_BACK: begin
        x = -one_v; y = row_v; z = col_v;
      end
      default: begin
        x = '0; y = '0; z = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      out_data <= {5'd0, z[DIR_W-1:0], y[DIR_W-1:0], x[DIR_W-1:0], ctl.face};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/cube_cross_ray_direction.sv -----
// Top level of the cube cross ray direction block: APB registers and the cell chain.
// Depends on ccrd_pkg, ccrd_classify, ccrd_div_cell and ccrd_pack.
//
// The block accepts one sample position per cycle unless the output stalls, and
// returns one face code and Q2.14 direction per sample, in order, through the
// classify stage, a chain of DIR_FRAC_BITS + 1 division cells and the pack stage,
// each cell producing one quotient bit of the row and column offsets; every
// stage holds its item while the output is stalled.
// Registers: image_width at byte address 0, image_height at byte address 4.
`default_nettype none

module cube_cross_ray_direction
  import ccrd_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int DIR_FRAC_BITS   = DIR_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // col_pos, row_pos
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // face_code, dir_x, dir_y, dir_z
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int DW    = REG_W + COORD_FRAC_BITS;
  localparam int CELLS = DIR_FRAC_BITS + 1;

  logic [REG_W-1:0] image_width;
  logic [REG_W-1:0] image_height;
  logic [DW-1:0]    den_w;
  logic [DW-1:0]    den_h;

  logic            valid   [0:CELLS];
  logic            ready   [0:CELLS];
  ccrd_ctl_t       ctl     [0:CELLS];
  logic [DW-1:0]   row_rem [0:CELLS];
  logic [DIR_FRAC_BITS:0] row_low [0:CELLS];
  logic [DIR_FRAC_BITS:0] row_q   [0:CELLS];
  logic [DW-1:0]   col_rem [0:CELLS];
  logic [DIR_FRAC_BITS:0] col_low [0:CELLS];
  logic [DIR_FRAC_BITS:0] col_q   [0:CELLS];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_SEL_WIDTH:  image_width  <= pwdata[REG_W-1:0];
        REG_SEL_HEIGHT: image_height <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SEL_WIDTH:  prdata = APB_DATA_W'(image_width);
      REG_SEL_HEIGHT: prdata = APB_DATA_W'(image_height);
      default:        prdata = '0;
    endcase
  end

  assign den_w = DW'(image_width) << COORD_FRAC_BITS;
  assign den_h = DW'(image_height) << COORD_FRAC_BITS;

  ccrd_classify #(
    .CFB (COORD_FRAC_BITS),
    .DFB (DIR_FRAC_BITS)
  ) u_classify (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .col_pos      (s_tdata[POS_W-1:0]),
    .row_pos      (s_tdata[2*POS_W-1:POS_W]),
    .image_width  (image_width),
    .image_height (image_height),
    .out_valid    (valid[0]),
    .out_ready    (ready[0]),
    .ctl          (ctl[0]),
    .row_rem      (row_rem[0]),
    .row_low      (row_low[0]),
    .col_rem      (col_rem[0]),
    .col_low      (col_low[0])
  );

  assign row_q[0] = '0;
  assign col_q[0] = '0;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    ccrd_div_cell #(
      .CFB (COORD_FRAC_BITS),
      .DFB (DIR_FRAC_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .in_valid    (valid[i]),
      .in_ready    (ready[i]),
      .out_valid   (valid[i+1]),
      .out_ready   (ready[i+1]),
      .den_row     (den_h),
      .den_col     (den_w),
      .ctl_in      (ctl[i]),
      .row_rem_in  (row_rem[i]),
      .row_low_in  (row_low[i]),
      .row_q_in    (row_q[i]),
      .col_rem_in  (col_rem[i]),
      .col_low_in  (col_low[i]),
      .col_q_in    (col_q[i]),
      .ctl_out     (ctl[i+1]),
      .row_rem_out (row_rem[i+1]),
      .row_low_out (row_low[i+1]),
      .row_q_out   (row_q[i+1]),
      .col_rem_out (col_rem[i+1]),
      .col_low_out (col_low[i+1]),
      .col_q_out   (col_q[i+1])
    );
  end

  ccrd_pack #(
    .DFB (DIR_FRAC_BITS)
  ) u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid[CELLS]),
    .in_ready  (ready[CELLS]),
    .ctl       (ctl[CELLS]),
    .row_q     (row_q[CELLS]),
    .col_q     (col_q[CELLS]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

// ----- hdl/ccrd_checker.sv -----
// Port-level checker of the cube cross ray direction block and its bind.
// Depends on ccrd_pkg and cube_cross_ray_direction_defines.svh.
`default_nettype none
`include "cube_cross_ray_direction_defines.svh"

module ccrd_port_checker
  import ccrd_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata
);

  `CCRD_ASSERT(a_hold_valid, m_tvalid && !m_tready, ##1 m_tvalid)
  `CCRD_ASSERT(a_hold_data, m_tvalid && !m_tready, ##1 $stable(m_tdata))
  `CCRD_ASSERT(a_none_zero, m_tvalid && (m_tdata[2:0] == FACE_NONE), m_tdata[50:3] == '0)
  `CCRD_ASSERT(a_face_code, m_tvalid, (m_tdata[2:0] != 3'd7) && (m_tdata[55:51] == '0))
  `CCRD_ASSERT_NEXT(a_reset_idle, rst, !m_tvalid)

endmodule

bind cube_cross_ray_direction ccrd_port_checker u_ccrd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
